@@ rtl/uriec_pkg.sv @@
// Shared types, constants and helper functions for the URI percent encoder.
// Used by the front end, job queue, back end, top level and testbench; no dependencies.
package uriec_pkg;

   localparam logic [15:0] CHAR_PERCENT = 16'h0025;
   localparam logic [15:0] LEAD_FIRST   = 16'hD800;
   localparam logic [15:0] LEAD_LAST    = 16'hDBFF;
   localparam logic [15:0] TRAIL_FIRST  = 16'hDC00;
   localparam logic [15:0] TRAIL_LAST   = 16'hDFFF;
   localparam logic [20:0] SUPP_BASE    = 21'h10000;
   localparam logic [20:0] CP_MAX_1BYTE = 21'h00007F;
   localparam logic [20:0] CP_MAX_2BYTE = 21'h0007FF;
   localparam logic [20:0] CP_MAX_3BYTE = 21'h00FFFF;

   // Register byte addresses on the configuration port.
   localparam logic [3:0] ADDR_MAP_LOW  = 4'h0;
   localparam logic [3:0] ADDR_MAP_HIGH = 4'h8;

   typedef enum logic [1:0] {
      JOB_PASS,
      JOB_ERROR,
      JOB_ENCODE
   } job_kind_type;

   typedef enum logic [1:0] {
      PH_PERCENT,
      PH_HIGH,
      PH_LOW
   } phase_type;

   typedef struct packed {
      logic [1:0]      last_byte;
      logic [3:0][7:0] bytes;
   } utf8_type;

   typedef struct packed {
      job_kind_type    kind;
      logic [15:0]     pass_char;
      utf8_type        utf8;
      logic            string_last;
   } job_type;

   function automatic logic [15:0] hex_digit(input logic [3:0] v);
      logic [15:0] d;
      if (v < 4'd10) begin
         d = 16'h0030 + {12'd0, v};
      end else begin
         d = 16'h0037 + {12'd0, v};
      end
      return d;
   endfunction

   // UTF-8 bytes of a code point, first byte in slot 0.
   function automatic utf8_type encode_utf8(input logic [20:0] cp);
      utf8_type u;
      u.bytes = '0;
      if (cp <= CP_MAX_1BYTE) begin
         u.last_byte = 2'd0;
         u.bytes[0]  = {1'b0, cp[6:0]};
      end else if (cp <= CP_MAX_2BYTE) begin
         u.last_byte = 2'd1;
         u.bytes[0]  = {3'b110, cp[10:6]};
         u.bytes[1]  = {2'b10, cp[5:0]};
      end else if (cp <= CP_MAX_3BYTE) begin
         u.last_byte = 2'd2;
         u.bytes[0]  = {4'b1110, cp[15:12]};
         u.bytes[1]  = {2'b10, cp[11:6]};
         u.bytes[2]  = {2'b10, cp[5:0]};
      end else begin
         u.last_byte = 2'd3;
         u.bytes[0]  = {5'b11110, cp[20:18]};
         u.bytes[1]  = {2'b10, cp[17:12]};
         u.bytes[2]  = {2'b10, cp[11:6]};
         u.bytes[3]  = {2'b10, cp[5:0]};
      end
      return u;
   endfunction

endpackage

@@ rtl/uriec_if.sv @@
// Valid/ready channel interfaces for code units in and encoded characters out.
// Depends on nothing; used by the top level, front end and back end.
interface uriec_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic        string_last;

   modport source (output valid, output code_unit, output string_last, input ready);
   modport sink   (input valid, input code_unit, input string_last, output ready);
endinterface

interface uriec_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] out_char;
   logic        run_last;
   logic        string_end;
   logic        uri_error;

   modport source (output valid, output out_char, output run_last, output string_end,
                   output uri_error, input ready);
   modport sink   (input valid, input out_char, input run_last, input string_end,
                   input uri_error, output ready);
endinterface

@@ rtl/uriec_front.sv @@
// Front end: accepts code units, tracks surrogate and discard state, and turns
// units into jobs for the back end. Depends on uriec_pkg and uriec_if.
module uriec_front (
   input  logic              clock,
   input  logic              reset,
   uriec_req_if.sink         req,
   input  logic [127:0]      unescaped_map,
   input  logic              queue_full,
   output logic              push_valid,
   output uriec_pkg::job_type push_job
);
   import uriec_pkg::*;

   logic [9:0] held_lead_ff, held_lead_in;
   logic       lead_pending_ff, lead_pending_in;
   logic       discarding_ff, discarding_in;

   logic        accept;
   logic        is_lead, is_trail, pass;
   logic [15:0] cu;
   logic        last;
   logic        job_valid;
   logic [20:0] cp;

   assign cu       = req.code_unit;
   assign last     = req.string_last;
   assign is_lead  = (cu >= LEAD_FIRST) && (cu <= LEAD_LAST);
   assign is_trail = (cu >= TRAIL_FIRST) && (cu <= TRAIL_LAST);
   assign pass     = (cu[15:7] == 9'd0) && unescaped_map[cu[6:0]];

   assign req.ready  = !queue_full;
   assign accept     = req.valid && !queue_full;
   assign push_valid = accept && job_valid;

   always_comb begin
      held_lead_in          = held_lead_ff;
      lead_pending_in       = lead_pending_ff;
      discarding_in         = discarding_ff;
      job_valid             = 1'b0;
      push_job.kind         = JOB_ENCODE;
      push_job.pass_char    = cu;
      push_job.string_last  = last;
      cp                    = {5'd0, cu};
      if (lead_pending_ff) begin
         cp = SUPP_BASE + {1'b0, held_lead_ff, cu[9:0]};
      end
      push_job.utf8 = encode_utf8(cp);

      if (discarding_ff) begin
         discarding_in = !last;
      end else if (lead_pending_ff) begin
         job_valid       = 1'b1;
         lead_pending_in = 1'b0;
         held_lead_in    = '0;
         if (!is_trail) begin
            push_job.kind = JOB_ERROR;
            discarding_in = !last;
         end
      end else if (pass) begin
         job_valid     = 1'b1;
         push_job.kind = JOB_PASS;
      end else if (is_trail || (is_lead && last)) begin
         job_valid     = 1'b1;
         push_job.kind = JOB_ERROR;
         discarding_in = !last;
      end else if (is_lead) begin
         lead_pending_in = 1'b1;
         held_lead_in    = cu[9:0];
      end else begin
         job_valid = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_lead_ff    <= '0;
         lead_pending_ff <= 1'b0;
         discarding_ff   <= 1'b0;
      end else if (accept) begin
         held_lead_ff    <= held_lead_in;
         lead_pending_ff <= lead_pending_in;
         discarding_ff   <= discarding_in;
      end
   end

endmodule

@@ rtl/uriec_queue.sv @@
// Short job queue between the front end and the back end.
// Depends on uriec_pkg for the job type.
module uriec_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  uriec_pkg::job_type push_job,
   input  logic               pop,
   output uriec_pkg::job_type head_job,
   output logic               full,
   output logic               empty
);
   import uriec_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ rtl/uriec_back.sv @@
// Back end: serializes one job per queue entry into characters, one per cycle while
// the result channel is not stalled, behind a registered result channel. Depends on uriec_pkg and uriec_if.
module uriec_back (
   input  logic               clock,
   input  logic               reset,
   input  uriec_pkg::job_type head_job,
   input  logic               head_valid,
   output logic               pop,
   uriec_rsp_if.source        rsp
);
   import uriec_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [1:0]  byte_sel_ff, byte_sel_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] out_char_ff, out_char_in;
   logic        run_last_ff, run_last_in;
   logic        string_end_ff, string_end_in;
   logic        uri_error_ff, uri_error_in;

   logic        advance, emit, final_byte;
   logic [7:0]  cur_byte;

   // The output register may be refilled when empty or when its transfer completes.
   assign advance    = !rsp_valid_ff || rsp.ready;
   assign emit       = head_valid && advance;
   assign cur_byte   = head_job.utf8.bytes[byte_sel_ff];
   assign final_byte = (byte_sel_ff == head_job.utf8.last_byte);

   always_comb begin
      phase_in      = phase_ff;
      byte_sel_in   = byte_sel_ff;
      pop           = 1'b0;
      out_char_in   = out_char_ff;
      run_last_in   = run_last_ff;
      string_end_in = string_end_ff;
      uri_error_in  = uri_error_ff;
      rsp_valid_in  = advance ? head_valid : rsp_valid_ff;
      if (emit) begin
         uri_error_in = 1'b0;
         unique case (head_job.kind)
            JOB_PASS: begin
               out_char_in   = head_job.pass_char;
               run_last_in   = 1'b1;
               string_end_in = head_job.string_last;
               pop           = 1'b1;
            end
            JOB_ERROR: begin
               out_char_in   = '0;
               run_last_in   = 1'b1;
               string_end_in = 1'b1;
               uri_error_in  = 1'b1;
               pop           = 1'b1;
            end
            JOB_ENCODE: begin
               run_last_in   = 1'b0;
               string_end_in = 1'b0;
               unique case (phase_ff)
                  PH_PERCENT: begin
                     out_char_in = CHAR_PERCENT;
                     phase_in    = PH_HIGH;
                  end
                  PH_HIGH: begin
                     out_char_in = hex_digit(cur_byte[7:4]);
                     phase_in    = PH_LOW;
                  end
                  PH_LOW: begin
                     out_char_in = hex_digit(cur_byte[3:0]);
                     phase_in    = PH_PERCENT;
                     if (final_byte) begin
                        run_last_in   = 1'b1;
                        string_end_in = head_job.string_last;
                        byte_sel_in   = '0;
                        pop           = 1'b1;
                     end else begin
                        byte_sel_in = byte_sel_ff + 1'b1;
                     end
                  end
                  default: begin
                     phase_in = PH_PERCENT;
                  end
               endcase
            end
            default: begin
               pop = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_PERCENT;
         byte_sel_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         byte_sel_ff  <= byte_sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_char_ff   <= out_char_in;
      run_last_ff   <= run_last_in;
      string_end_ff <= string_end_in;
      uri_error_ff  <= uri_error_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.out_char   = out_char_ff;
   assign rsp.run_last   = run_last_ff;
   assign rsp.string_end = string_end_ff;
   assign rsp.uri_error  = uri_error_ff;

endmodule

@@ rtl/uri_percent_encoder_top.sv @@
// URI percent encoder, UTF-16 code units in, percent-encoded characters out.
// Each unit's job passes through the job queue and the back end output register.
// Throughput: one code unit per cycle while units pass unescaped and the queue is
// not full; an encoded unit holds the serializer for 3, 6, 9 or 12 characters, and
// the job queue (QUEUE_DEPTH entries) lets the front keep accepting meanwhile.
// Reset clears surrogate/discard state, the queue, the output and both maps.
module uri_percent_encoder_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   uriec_req_if.sink   req_chan,
   uriec_rsp_if.source rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import uriec_pkg::*;

   logic [63:0] map_low_ff, map_high_ff;
   logic        csr_write;

   logic        push_valid, queue_full, queue_empty, pop;
   job_type     push_job, head_job;

   // Only address bit 3 selects a register; the low bits are ignored.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[3] == ADDR_MAP_HIGH[3]) ? map_high_ff : map_low_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_low_ff  <= '0;
         map_high_ff <= '0;
      end else if (csr_write) begin
         if (csr_paddr[3] == ADDR_MAP_HIGH[3]) begin
            map_high_ff <= csr_pwdata;
         end else begin
            map_low_ff <= csr_pwdata;
         end
      end
   end

   uriec_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req           (req_chan),
      .unescaped_map ({map_high_ff, map_low_ff}),
      .queue_full    (queue_full),
      .push_valid    (push_valid),
      .push_job      (push_job)
   );

   uriec_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push_valid),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .full     (queue_full),
      .empty    (queue_empty)
   );

   uriec_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_job   (head_job),
      .head_valid (!queue_empty),
      .pop        (pop),
      .rsp        (rsp_chan)
   );

endmodule

@@ rtl/uriec_checker.sv @@
// Port-level checks on the result channel of the URI percent encoder,
// attached to uri_percent_encoder_top by the bind statement below.
module uriec_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_out_char,
   input logic        rsp_run_last,
   input logic        rsp_string_end,
   input logic        rsp_uri_error
);

   // A stalled result holds its value until the transfer completes.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_char)
         && $stable(rsp_run_last) && $stable(rsp_string_end) && $stable(rsp_uri_error))
      else $error("result changed while stalled");

   a_error_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_uri_error |-> rsp_out_char == 16'h0000 && rsp_run_last
         && rsp_string_end)
      else $error("error result is malformed");

   a_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_string_end |-> rsp_run_last)
      else $error("string end without run end");

   // Any character before the end of a run comes from an escape triple.
   a_escape_chars: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_run_last |-> !rsp_uri_error && (rsp_out_char == 16'h0025
         || (rsp_out_char >= 16'h0030 && rsp_out_char <= 16'h0039)
         || (rsp_out_char >= 16'h0041 && rsp_out_char <= 16'h0046)))
      else $error("unexpected character inside an escape run");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind uri_percent_encoder_top uriec_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_out_char   (rsp_chan.out_char),
   .rsp_run_last   (rsp_chan.run_last),
   .rsp_string_end (rsp_chan.string_end),
   .rsp_uri_error  (rsp_chan.uri_error)
);

@@ tb/uri_percent_encoder_top_tb.sv @@
// Self-checking testbench for the URI percent encoder top level.
// Needs uriec_pkg, the uriec_req_if/uriec_rsp_if interfaces and uri_percent_encoder_top;
// an in-bench encoder model predicts every character and compares it with the output.
module uri_percent_encoder_top_tb;
   import uriec_pkg::*;

   typedef struct packed {
      logic [15:0] out_char;
      logic        run_last;
      logic        string_end;
      logic        uri_error;
   } encoded_char_type;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [63:0] csr_pwdata;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   uriec_req_if req_if ();
   uriec_rsp_if rsp_if ();

   uri_percent_encoder_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Encoder model state and the characters it still expects.
   logic [63:0]      unescaped_low  = '0;
   logic [63:0]      unescaped_high = '0;
   logic [9:0]       lead_bits      = '0;
   logic             lead_waiting   = 1'b0;
   logic             dropping       = 1'b0;
   encoded_char_type pending_chars[$];

   int mismatch_count = 0;
   bit no_idle        = 1'b0;
   int stall_left     = 0;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   initial begin
      #3000000;
      $display("Verification failed");
      $finish;
   end

   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 9);
      return (r < 8) ? $urandom_range(1, 3) : $urandom_range(4, 30);
   endfunction

   function automatic logic [15:0] nibble_char(input logic [3:0] v);
      return (v < 4'd10) ? 16'h0030 + {12'd0, v} : 16'h0041 + {12'd0, v} - 16'd10;
   endfunction

   function automatic void push_char(input logic [15:0] c, input logic run_end,
                                     input logic last);
      encoded_char_type item;
      item.out_char   = c;
      item.run_last   = run_end;
      item.string_end = run_end && last;
      item.uri_error  = 1'b0;
      pending_chars   = {pending_chars, item};
   endfunction

   // A bad surrogate sequence ends the string; anything left of it is dropped.
   function automatic void push_error(input logic last);
      encoded_char_type item;
      item.out_char   = 16'h0000;
      item.run_last   = 1'b1;
      item.string_end = 1'b1;
      item.uri_error  = 1'b1;
      pending_chars   = {pending_chars, item};
      lead_waiting    = 1'b0;
      lead_bits       = '0;
      dropping        = !last;
   endfunction

   function automatic void encode_unit(input logic [15:0] cu, input logic last);
      logic [127:0] passes;
      logic [20:0]  cp;
      logic [7:0]   utf8[4];
      int           nbytes;
      logic         is_lead;
      logic         is_trail;
      passes   = {unescaped_high, unescaped_low};
      is_lead  = cu >= LEAD_FIRST && cu <= LEAD_LAST;
      is_trail = cu >= TRAIL_FIRST && cu <= TRAIL_LAST;
      if (dropping) begin
         if (last) dropping = 1'b0;
         return;
      end
      if (lead_waiting) begin
         if (!is_trail) begin
            push_error(last);
            return;
         end
         cp = SUPP_BASE + {1'b0, lead_bits, cu[9:0]};
         lead_waiting = 1'b0;
         lead_bits    = '0;
      end else if (cu < 16'd128 && passes[cu[6:0]]) begin
         push_char(cu, 1'b1, last);
         return;
      end else if (is_trail) begin
         push_error(last);
         return;
      end else if (is_lead) begin
         if (last) begin
            push_error(last);
         end else begin
            lead_bits    = cu[9:0];
            lead_waiting = 1'b1;
         end
         return;
      end else begin
         cp = {5'd0, cu};
      end

      if (cp <= CP_MAX_1BYTE) begin
         utf8[0] = cp[7:0];
         nbytes  = 1;
      end else if (cp <= CP_MAX_2BYTE) begin
         utf8[0] = {3'b110, cp[10:6]};
         utf8[1] = {2'b10, cp[5:0]};
         nbytes  = 2;
      end else if (cp <= CP_MAX_3BYTE) begin
         utf8[0] = {4'b1110, cp[15:12]};
         utf8[1] = {2'b10, cp[11:6]};
         utf8[2] = {2'b10, cp[5:0]};
         nbytes  = 3;
      end else begin
         utf8[0] = {5'b11110, cp[20:18]};
         utf8[1] = {2'b10, cp[17:12]};
         utf8[2] = {2'b10, cp[11:6]};
         utf8[3] = {2'b10, cp[5:0]};
         nbytes  = 4;
      end
      for (int i = 0; i < nbytes; i++) begin
         push_char(CHAR_PERCENT, 1'b0, last);
         push_char(nibble_char(utf8[i][7:4]), 1'b0, last);
         push_char(nibble_char(utf8[i][3:0]), i == nbytes - 1, last);
      end
   endfunction

   // Register writes, code unit transfers and result transfers are all observed here,
   // in one process, so the model sees them in clock order.
   always @(posedge clock) begin : observe
      encoded_char_type want;
      if (!reset) begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr)
               ADDR_MAP_LOW:  unescaped_low  = csr_pwdata;
               ADDR_MAP_HIGH: unescaped_high = csr_pwdata;
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready) begin
            encode_unit(req_if.code_unit, req_if.string_last);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_chars.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("unexpected result at %0t: char %h run_last %b end %b error %b",
                           $time, rsp_if.out_char, rsp_if.run_last, rsp_if.string_end,
                           rsp_if.uri_error);
               end
            end else begin
               want = pending_chars.pop_front();
               if (rsp_if.out_char !== want.out_char || rsp_if.run_last !== want.run_last ||
                   rsp_if.string_end !== want.string_end ||
                   rsp_if.uri_error !== want.uri_error) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("mismatch at %0t: expected char %h run_last %b end %b error %b",
                              $time, want.out_char, want.run_last, want.string_end,
                              want.uri_error);
                     $display("                 got char %h run_last %b end %b error %b",
                              rsp_if.out_char, rsp_if.run_last, rsp_if.string_end,
                              rsp_if.uri_error);
                  end
               end
            end
         end
      end
   end

   // Result side backpressure: mostly ready, short stalls, now and then a long one.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (no_idle) begin
         rsp_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else if ($urandom_range(0, 9) < 7) begin
         rsp_if.ready <= 1'b1;
      end else begin
         rsp_if.ready <= 1'b0;
         stall_left   <= idle_cycles() - 1;
      end
   end

   // Called at a rising edge; returns at the edge where the transfer happens with
   // valid still high, so a following unit can go out without a gap.
   task automatic send_code_unit(input logic [15:0] cu, input logic last);
      int gap;
      gap = (no_idle || $urandom_range(0, 1) == 0) ? 0 : idle_cycles();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.code_unit   <= cu;
      req_if.string_last <= last;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Lead surrogates and dropped units give no result, so the wait goes on past
   // the last expected character before the block counts as idle.
   task automatic drain_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic apb_write(input logic [3:0] addr, input logic [63:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic write_maps(input logic [63:0] low, input logic [63:0] high);
      apb_write(ADDR_MAP_LOW, low);
      apb_write(ADDR_MAP_HIGH, high);
   endtask

   // One string of mostly well-formed text with some broken surrogates mixed in.
   task automatic send_random_string(output int units);
      int          len;
      int          kind;
      logic        is_end;
      logic [15:0] cu;
      len   = $urandom_range(1, 8);
      units = 0;
      for (int i = 0; i < len; i++) begin
         is_end = (i == len - 1);
         kind   = $urandom_range(0, 99);
         if (kind < 22) begin
            send_code_unit(16'($urandom_range(LEAD_FIRST, LEAD_LAST)), 1'b0);
            send_code_unit(16'($urandom_range(TRAIL_FIRST, TRAIL_LAST)), is_end);
            units += 2;
         end else begin
            if (kind < 60) begin
               cu = 16'($urandom_range(0, 127));
            end else if (kind < 70) begin
               cu = 16'($urandom_range(16'h0080, 16'h07FF));
            end else if (kind < 82) begin
               cu = ($urandom_range(0, 1) != 0)
                  ? 16'($urandom_range(16'h0800, LEAD_FIRST - 1))
                  : 16'($urandom_range(TRAIL_LAST + 1, 16'hFFFF));
            end else if (kind < 86) begin
               cu = 16'($urandom_range(LEAD_FIRST, LEAD_LAST));
            end else if (kind < 90) begin
               cu = 16'($urandom_range(TRAIL_FIRST, TRAIL_LAST));
            end else begin
               cu = 16'($urandom_range(0, 16'hFFFF));
            end
            send_code_unit(cu, is_end);
            units++;
         end
      end
   endtask

   task automatic send_random_text(input int count);
      int sent;
      int k;
      sent = 0;
      while (sent < count) begin
         send_random_string(k);
         sent += k;
      end
      drain_results();
   endtask

   // With both maps cleared after reset every unit is escaped, each UTF-8 length
   // and both ends of the supplementary range among them.
   task automatic test_default_map_encoding();
      send_code_unit(16'h0000, 1'b0);
      send_code_unit(16'h007F, 1'b0);
      send_code_unit(16'h0080, 1'b0);
      send_code_unit(16'h07FF, 1'b0);
      send_code_unit(16'h0800, 1'b0);
      send_code_unit(16'hFFFF, 1'b0);
      send_code_unit(LEAD_FIRST, 1'b0);
      send_code_unit(TRAIL_FIRST, 1'b0);
      send_code_unit(LEAD_LAST, 1'b0);
      send_code_unit(TRAIL_LAST, 1'b1);
      drain_results();
   endtask

   task automatic test_passthrough_extremes();
      write_maps('1, '1);
      send_code_unit(16'h0000, 1'b0);
      send_code_unit(16'h007F, 1'b0);
      send_code_unit(16'h0041, 1'b0);
      send_code_unit(16'h0080, 1'b1);
      drain_results();
   endtask

   // Every map bit is still set, so a unit that follows a lead must give an error
   // even though it would otherwise pass.
   task automatic test_surrogate_errors();
      send_code_unit(16'hD834, 1'b0);
      send_code_unit(16'h0041, 1'b0);
      send_code_unit(16'h0042, 1'b0);
      send_code_unit(16'h0043, 1'b1);
      send_code_unit(TRAIL_FIRST, 1'b1);
      send_code_unit(LEAD_LAST, 1'b1);
      send_code_unit(16'hD800, 1'b0);
      send_code_unit(16'hDA00, 1'b0);
      send_code_unit(16'h0078, 1'b1);
      send_code_unit(16'h007A, 1'b1);
      drain_results();
   endtask

   task automatic test_random_maps();
      write_maps('0, '0);
      send_random_text(22);
      write_maps('1, '1);
      send_random_text(22);
      write_maps({$urandom(), $urandom()}, {$urandom(), $urandom()});
      send_random_text(22);
      write_maps({$urandom(), $urandom()}, {$urandom(), $urandom()});
      send_random_text(22);
      write_maps({32{2'b01}}, {32{2'b10}});
      send_random_text(22);
   endtask

   task automatic test_back_to_back();
      write_maps({$urandom(), $urandom()}, {$urandom(), $urandom()});
      no_idle = 1'b1;
      send_random_text(24);
      no_idle = 1'b0;
   endtask

   initial begin
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.code_unit   = '0;
      req_if.string_last = 1'b0;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_default_map_encoding();
      test_passthrough_extremes();
      test_surrogate_errors();
      test_random_maps();
      test_back_to_back();

      if (mismatch_count == 0 && pending_chars.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule

@@ files.f @@
rtl/uriec_pkg.sv
rtl/uriec_if.sv
rtl/uriec_front.sv
rtl/uriec_queue.sv
rtl/uriec_back.sv
rtl/uri_percent_encoder_top.sv
rtl/uriec_checker.sv
tb/uri_percent_encoder_top_tb.sv
